FILE: rtl/kisl_pkg.sv
package kisl_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int SUM_W       = 52;
  localparam int DIV_W       = 81;
  localparam int DEN_W       = 65;

  typedef enum logic [1:0] {
    CMD_ADVANCE = 2'd0,
    CMD_SET_ACC = 2'd1,
    CMD_BRAKE   = 2'd2,
    CMD_SET_POS = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [1:0]                    cmd;
    logic [31:0]                   time_now;
    logic signed [VALUE_WIDTH-1:0] accel_x;
    logic signed [VALUE_WIDTH-1:0] accel_y;
    logic signed [VALUE_WIDTH-1:0] accel_z;
    logic [30:0]                   speed_limit;
    logic signed [VALUE_WIDTH-1:0] pos_x;
    logic signed [VALUE_WIDTH-1:0] pos_y;
    logic signed [VALUE_WIDTH-1:0] pos_z;
  } in_t;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] out_pos_x;
    logic signed [VALUE_WIDTH-1:0] out_pos_y;
    logic signed [VALUE_WIDTH-1:0] out_pos_z;
    logic signed [VALUE_WIDTH-1:0] out_vel_x;
    logic signed [VALUE_WIDTH-1:0] out_vel_y;
    logic signed [VALUE_WIDTH-1:0] out_vel_z;
  } out_t;

  typedef enum logic [4:0] {
    S_IDLE, S_ADV, S_NV_M, S_NV_A, S_MAG_M, S_MAG_A, S_LIM_M, S_LIM_A,
    S_SQ, S_SQ_END, S_SC_M, S_SC_D, S_DIV, S_DIV_END, S_POS_M, S_POS_A,
    S_POS_M2, S_POS_W, S_POST, S_DOT_M, S_DOT_A, S_A2_M, S_A2_A,
    S_XP_M, S_XP_A, S_FIN
  } st_t;

  // Saturates a wide signed sum to the stored value width.
  function automatic logic signed [VALUE_WIDTH-1:0] sat_val(input logic signed [SUM_W-1:0] x);
    logic signed [SUM_W-1:0] vmax;
    logic signed [SUM_W-1:0] vmin;
    vmax = SUM_W'({1'b0, {(VALUE_WIDTH-1){1'b1}}});
    vmin = -vmax - SUM_W'(1);
    if (x > vmax) begin
      return {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    end else if (x < vmin) begin
      return {1'b1, {(VALUE_WIDTH-1){1'b0}}};
    end
    return x[VALUE_WIDTH-1:0];
  endfunction

endpackage

FILE: rtl/kinematic_integrator_speed_limit.sv
// Kinematic integrator with a speed cap, three axes, Q16.16 fixed point.
// Requests arrive on in_valid/in_ready with one in_t item; each request gives
// exactly one out_t result (position and velocity after the action) on
// out_valid/out_ready. The block takes one request at a time: in_ready is high
// only while it is idle.
// How long a request takes depends on the command and the state. Set position
// only loads the position, and a request with no elapsed time skips the
// integration. A plain advance integrates velocity and position per axis, with
// a magnitude check when a speed limit is set and an extra coast term when the
// step splits into accelerate and coast phases. Applying the cap adds a 64-step
// square root and three 81-step divisions. A set-acceleration request then
// either clamps the speed when it is already at or above the new limit or solves
// for the time to reach the limit with a further square root and division. The
// next request can be taken in the cycle after out_valid rises at the earliest.
// All of this runs in turn on one shared 33x33 multiplier, a bit-serial
// restoring square root and a bit-serial restoring divider.
// Reset clears position, velocity, acceleration, limit, time to limit and
// the last time stamp, and drops out_valid. If the receiver stalls, the
// finished result stays in the output register; a new request may be taken
// meanwhile, and its result waits in the sequencer until the register frees.
module kinematic_integrator_speed_limit
  import kisl_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_item,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_item
);

  st_t state, state_next;

  // Architectural state.
  logic signed [31:0] pos [3];
  logic signed [31:0] vel [3];
  logic signed [31:0] acc [3];
  logic [30:0]        lim;
  logic [31:0]        ttl;
  logic               never;
  logic [31:0]        last;

  // Working registers.
  in_t                item;
  logic signed [31:0] nv [3];
  logic [1:0]         idx;
  logic [6:0]         cnt;
  logic               split;
  logic [30:0]        h;
  logic [30:0]        tc;
  logic               set_ctx;
  logic               use_ttl;
  logic [63:0]        s2;
  logic [61:0]        l2;
  logic signed [65:0] dsum;
  logic [63:0]        dmag;
  logic               dneg;
  logic [63:0]        a2;
  logic [127:0]       xacc;
  logic signed [SUM_W-1:0] ptmp;
  logic signed [65:0] prod;
  logic signed [32:0] mul_a, mul_b;
  logic [127:0]       sq_x;
  logic [65:0]        sq_rem;
  logic [63:0]        sq_root;
  logic [DIV_W-1:0]   dv_num;
  logic [DEN_W-1:0]   dv_rem;
  logic [DEN_W-1:0]   dv_den;
  logic               dv_neg;

  // Combinational helpers.
  logic [31:0]        diff;
  logic               adv_skip, split_c;
  logic               last_idx;
  logic               clamp_go;
  logic [63:0]        e64;
  logic               new_acc_zero;
  logic [64:0]        root_sum;
  logic [DIV_W-1:0]   tt_num;
  logic [DEN_W-1:0]   tt_den;
  logic [67:0]        sq_r, sq_trial;
  logic               sq_ge;
  logic [65:0]        dv_r;
  logic               dv_ge;
  logic [127:0]       xp_add;
  logic [31:0]        xp_a, xp_b;
  logic [6:0]         xp_sh;
  logic signed [65:0] sc_mag;
  logic signed [31:0] sc_val;
  logic signed [32:0] vsum;
  logic [31:0]        qv;

  assign diff         = item.time_now - last;
  assign adv_skip     = (diff == 32'd0) || diff[31];
  assign split_c      = !never && (ttl != 32'd0) && (diff > ttl);
  assign last_idx     = (idx == 2'd2);
  assign clamp_go     = set_ctx ? (s2 >= {2'b00, prod[61:0]}) : (s2 > {2'b00, prod[61:0]});
  assign e64          = {2'b00, l2} - s2;
  assign new_acc_zero = (item.accel_x == '0) && (item.accel_y == '0) && (item.accel_z == '0);
  assign root_sum     = {1'b0, dmag} + {1'b0, sq_root};
  assign tt_num       = dneg ? {root_sum, {FRAC_BITS{1'b0}}} : {3'b000, e64[61:0], {FRAC_BITS{1'b0}}};
  assign tt_den       = dneg ? {1'b0, a2} : root_sum;
  assign sq_r         = {sq_rem, sq_x[127:126]};
  assign sq_trial     = {2'b00, sq_root, 2'b01};
  assign sq_ge        = (sq_r >= sq_trial);
  assign dv_r         = {dv_rem, dv_num[DIV_W-1]};
  assign dv_ge        = (dv_r >= {1'b0, dv_den});
  assign sc_mag       = prod[65] ? -prod : prod;
  assign qv           = dv_num[31:0];
  assign sc_val       = dv_neg ? -$signed(qv) : $signed(qv);
  assign vsum         = {vel[idx][31], vel[idx]} + {nv[idx][31], nv[idx]};

  // Partial product schedule for D^2 + A*E, 32x32 unsigned pieces.
  always_comb begin
    unique case (cnt[2:0])
      3'd0: begin xp_a = dmag[31:0];  xp_b = dmag[31:0];  xp_sh = 7'd0;  end
      3'd1: begin xp_a = dmag[31:0];  xp_b = dmag[63:32]; xp_sh = 7'd32; end
      3'd2: begin xp_a = dmag[63:32]; xp_b = dmag[31:0];  xp_sh = 7'd32; end
      3'd3: begin xp_a = dmag[63:32]; xp_b = dmag[63:32]; xp_sh = 7'd64; end
      3'd4: begin xp_a = a2[31:0];    xp_b = e64[31:0];   xp_sh = 7'd0;  end
      3'd5: begin xp_a = a2[31:0];    xp_b = e64[63:32];  xp_sh = 7'd32; end
      3'd6: begin xp_a = a2[63:32];   xp_b = e64[31:0];   xp_sh = 7'd32; end
      default: begin xp_a = a2[63:32]; xp_b = e64[63:32]; xp_sh = 7'd64; end
    endcase
    xp_add = {64'd0, prod[63:0]} << xp_sh;
  end

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_NV_M:   begin mul_a = {acc[idx][31], acc[idx]}; mul_b = {2'b00, h}; end
      S_MAG_M:  begin mul_a = {nv[idx][31], nv[idx]};   mul_b = {nv[idx][31], nv[idx]}; end
      S_LIM_M:  begin mul_a = {2'b00, lim};             mul_b = {2'b00, lim}; end
      S_SC_M:   begin mul_a = {nv[idx][31], nv[idx]};   mul_b = {2'b00, lim}; end
      S_POS_M:  begin mul_a = vsum;                     mul_b = {2'b00, h}; end
      S_POS_M2: begin mul_a = {nv[idx][31], nv[idx]};   mul_b = {2'b00, tc}; end
      S_DOT_M:  begin mul_a = {vel[idx][31], vel[idx]}; mul_b = {acc[idx][31], acc[idx]}; end
      S_A2_M:   begin mul_a = {acc[idx][31], acc[idx]}; mul_b = {acc[idx][31], acc[idx]}; end
      S_XP_M:   begin mul_a = {1'b0, xp_a};             mul_b = {1'b0, xp_b}; end
      default:  begin mul_a = '0;                       mul_b = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = (state == S_IDLE);
    unique case (state)
      S_IDLE:    if (in_valid) state_next = S_ADV;
      S_ADV: begin
        if (item.cmd == CMD_SET_POS) state_next = S_FIN;
        else if (adv_skip)           state_next = S_POST;
        else                         state_next = S_NV_M;
      end
      S_NV_M:    state_next = S_NV_A;
      S_NV_A: begin
        if (!last_idx)       state_next = S_NV_M;
        else if (lim == '0)  state_next = S_POS_M;
        else                 state_next = S_MAG_M;
      end
      S_MAG_M:   state_next = S_MAG_A;
      S_MAG_A:   state_next = last_idx ? S_LIM_M : S_MAG_M;
      S_LIM_M:   state_next = S_LIM_A;
      S_LIM_A: begin
        if (clamp_go)     state_next = S_SQ;
        else if (set_ctx) state_next = S_DOT_M;
        else              state_next = S_POS_M;
      end
      S_SQ:      if (cnt == 7'd63) state_next = S_SQ_END;
      S_SQ_END: begin
        if (use_ttl)               state_next = (tt_den == '0) ? S_FIN : S_DIV;
        else if (sq_root == '0)    state_next = set_ctx ? S_FIN : S_POS_M;
        else                       state_next = S_SC_M;
      end
      S_SC_M:    state_next = S_SC_D;
      S_SC_D:    state_next = S_DIV;
      S_DIV:     if (cnt == 7'(DIV_W - 1)) state_next = S_DIV_END;
      S_DIV_END: begin
        if (use_ttl)        state_next = S_FIN;
        else if (!last_idx) state_next = S_SC_M;
        else                state_next = set_ctx ? S_FIN : S_POS_M;
      end
      S_POS_M:   state_next = S_POS_A;
      S_POS_A: begin
        if (split)          state_next = S_POS_M2;
        else                state_next = last_idx ? S_POST : S_POS_M;
      end
      S_POS_M2:  state_next = S_POS_W;
      S_POS_W:   state_next = last_idx ? S_POST : S_POS_M;
      S_POST: begin
        if (item.cmd == CMD_SET_ACC && !new_acc_zero && item.speed_limit != '0)
          state_next = S_MAG_M;
        else
          state_next = S_FIN;
      end
      S_DOT_M:   state_next = S_DOT_A;
      S_DOT_A:   state_next = last_idx ? S_A2_M : S_DOT_M;
      S_A2_M:    state_next = S_A2_A;
      S_A2_A:    state_next = last_idx ? S_XP_M : S_A2_M;
      S_XP_M:    state_next = S_XP_A;
      S_XP_A:    state_next = (cnt == 7'd7) ? S_SQ : S_XP_M;
      S_FIN:     if (!out_valid || out_ready) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        pos[i] <= '0;
        vel[i] <= '0;
        acc[i] <= '0;
      end
      lim       <= '0;
      ttl       <= '0;
      never     <= 1'b0;
      last      <= '0;
      out_valid <= 1'b0;
    end else begin
      // The result register is reloaded from S_FIN; otherwise it empties on a handshake.
      if (out_valid && out_ready && state != S_FIN) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) item <= in_item;
        end
        S_ADV: begin
          set_ctx <= 1'b0;
          use_ttl <= 1'b0;
          idx     <= 2'd0;
          s2      <= '0;
          if (item.cmd == CMD_SET_POS) begin
            pos[0] <= item.pos_x;
            pos[1] <= item.pos_y;
            pos[2] <= item.pos_z;
            last   <= item.time_now;
          end else if (!adv_skip) begin
            split <= split_c;
            h     <= split_c ? ttl[30:0] : diff[30:0];
            tc    <= diff[30:0] - ttl[30:0];
            ttl   <= (ttl > diff) ? ttl - diff : 32'd0;
            last  <= item.time_now;
          end
        end
        S_NV_A: begin
          nv[idx] <= sat_val({{(SUM_W-32){vel[idx][31]}}, vel[idx]}
                             + SUM_W'(prod >>> FRAC_BITS));
          idx <= last_idx ? 2'd0 : idx + 2'd1;
        end
        S_MAG_A: begin
          s2  <= s2 + prod[63:0];
          idx <= last_idx ? 2'd0 : idx + 2'd1;
        end
        S_LIM_A: begin
          l2  <= prod[61:0];
          idx <= 2'd0;
          if (clamp_go) begin
            sq_x    <= {64'd0, s2};
            sq_rem  <= '0;
            sq_root <= '0;
            cnt     <= '0;
          end
        end
        S_SQ: begin
          sq_rem  <= sq_ge ? 66'(sq_r - sq_trial) : sq_r[65:0];
          sq_root <= {sq_root[62:0], sq_ge};
          sq_x    <= {sq_x[125:0], 2'b00};
          cnt     <= cnt + 7'd1;
        end
        S_SQ_END: begin
          idx <= 2'd0;
          cnt <= '0;
          if (use_ttl) begin
            if (tt_den == '0) begin
              never <= 1'b1;
            end
            dv_num <= tt_num;
            dv_den <= tt_den;
            dv_rem <= '0;
            dv_neg <= 1'b0;
          end
        end
        S_SC_D: begin
          dv_num <= {18'd0, sc_mag[62:0]};
          dv_den <= {33'd0, sq_root[31:0]};
          dv_rem <= '0;
          dv_neg <= prod[65];
          cnt    <= '0;
        end
        S_DIV: begin
          dv_rem <= dv_ge ? DEN_W'(dv_r - {1'b0, dv_den}) : dv_r[DEN_W-1:0];
          dv_num <= {dv_num[DIV_W-2:0], dv_ge};
          cnt    <= cnt + 7'd1;
        end
        S_DIV_END: begin
          if (use_ttl) begin
            if (dv_num[DIV_W-1:32] != '0) never <= 1'b1;
            else                          ttl   <= dv_num[31:0];
          end else begin
            nv[idx] <= sc_val;
            idx     <= last_idx ? 2'd0 : idx + 2'd1;
            if (last_idx && set_ctx) begin
              for (int i = 0; i < 3; i++) begin
                vel[i] <= (2'(i) == idx) ? sc_val : nv[i];
              end
            end
          end
        end
        S_POS_A: begin
          ptmp <= SUM_W'(prod >>> (FRAC_BITS + 1));
          if (!split) begin
            pos[idx] <= sat_val({{(SUM_W-32){pos[idx][31]}}, pos[idx]}
                                + SUM_W'(prod >>> (FRAC_BITS + 1)));
            idx <= last_idx ? 2'd0 : idx + 2'd1;
            if (last_idx) begin
              for (int i = 0; i < 3; i++) vel[i] <= nv[i];
            end
          end
        end
        S_POS_W: begin
          pos[idx] <= sat_val({{(SUM_W-32){pos[idx][31]}}, pos[idx]} + ptmp
                              + SUM_W'(prod >>> FRAC_BITS));
          idx <= last_idx ? 2'd0 : idx + 2'd1;
          if (last_idx) begin
            for (int i = 0; i < 3; i++) vel[i] <= nv[i];
          end
        end
        S_POST: begin
          idx  <= 2'd0;
          s2   <= '0;
          dsum <= '0;
          a2   <= '0;
          xacc <= '0;
          if (item.cmd == CMD_SET_ACC) begin
            acc[0]  <= item.accel_x;
            acc[1]  <= item.accel_y;
            acc[2]  <= item.accel_z;
            lim     <= item.speed_limit;
            ttl     <= '0;
            never   <= 1'b0;
            set_ctx <= 1'b1;
            for (int i = 0; i < 3; i++) nv[i] <= vel[i];
          end else if (item.cmd == CMD_BRAKE) begin
            for (int i = 0; i < 3; i++) begin
              acc[i] <= '0;
              vel[i] <= '0;
            end
            lim   <= '0;
            ttl   <= '0;
            never <= 1'b0;
            last  <= item.time_now;
          end
        end
        S_DOT_A: begin
          dsum <= dsum + prod;
          idx  <= last_idx ? 2'd0 : idx + 2'd1;
          if (last_idx) begin
            dneg <= (dsum + prod) < 0;
            dmag <= ((dsum + prod) < 0) ? 64'(-(dsum + prod)) : 64'(dsum + prod);
          end
        end
        S_A2_A: begin
          a2  <= a2 + prod[63:0];
          idx <= last_idx ? 2'd0 : idx + 2'd1;
          cnt <= '0;
        end
        S_XP_A: begin
          xacc <= xacc + xp_add;
          cnt  <= (cnt == 7'd7) ? 7'd0 : cnt + 7'd1;
          if (cnt == 7'd7) begin
            sq_x    <= xacc + xp_add;
            sq_rem  <= '0;
            sq_root <= '0;
            use_ttl <= 1'b1;
          end
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            out_item.out_pos_x <= pos[0];
            out_item.out_pos_y <= pos[1];
            out_item.out_pos_z <= pos[2];
            out_item.out_vel_x <= vel[0];
            out_item.out_vel_y <= vel[1];
            out_item.out_vel_z <= vel[2];
            out_valid          <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // A pending time to limit excludes the never-reached flag.
  a_ttl_never: assert property (@(posedge clk) disable iff (rst)
    (ttl != 32'd0) |-> !never)
    else $error("time to limit set while limit marked unreachable");

  // The divider never runs with a zero divisor.
  a_div_den: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (dv_den != '0))
    else $error("division started with zero divisor");

  // A brake leaves the block at rest before its result goes out.
  a_brake_rest: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && item.cmd == CMD_BRAKE) |->
      (vel[0] == '0 && vel[1] == '0 && vel[2] == '0 && lim == '0 && !never))
    else $error("brake did not clear the motion");

  // An accepted request always starts the sequencer.
  a_start: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_ADV))
    else $error("accepted request did not start");

endmodule
